FILE: hw/rtl/fca_pkg.sv
// Shared types and constants of the cluster chain allocator.
// Used by fca_ctrl and the top level; depends on nothing.
package fca_pkg;

  // Table geometry
  localparam int unsigned TableEntries = 4096;
  localparam int unsigned AddrW        = $clog2(TableEntries);
  // Cluster size in bytes, must be a power of two
  localparam int unsigned ClusterBytes = 512;
  localparam int unsigned ClusterShift = $clog2(ClusterBytes);

  // Fixed field widths
  localparam int unsigned EntryW = 12;
  localparam int unsigned CountW = 13;
  localparam int unsigned BytesW = 22;
  localparam int unsigned NeedW  = BytesW + 1;

  localparam logic [EntryW-1:0] EndOfChain     = 12'hFFF;
  localparam logic [CountW-1:0] ScanLimitReset = 13'd2847;

  // Request modes
  localparam logic [1:0] ModeWrite = 2'd0;
  localparam logic [1:0] ModeRead  = 2'd1;
  localparam logic [1:0] ModeAlloc = 2'd2;

  // Result status codes
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoSpace = 2'd1;
  localparam logic [1:0] StZero    = 2'd2;

  // Table port requests from the sequencer
  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  waddr;
    logic [EntryW-1:0] wdata;
    logic [AddrW-1:0]  raddr;
  } mem_req_t;

  // One result
  typedef struct packed {
    logic              valid;
    logic [1:0]        status;
    logic [EntryW-1:0] first;
    logic [CountW-1:0] count;
    logic [EntryW-1:0] rd_value;
  } result_t;

endpackage

FILE: hw/rtl/fca_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fca_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write, then register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/fca_ctrl.sv
// Sequencer of the cluster chain allocator: clearing pass, entry read and
// write, and the free-entry scan with its increment and compare.
// Depends on fca_pkg.
module fca_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   mode_i,
  input  logic [11:0]                  entry_index_i,
  input  logic [11:0]                  entry_value_i,
  input  logic [21:0]                  byte_count_i,
  input  logic [12:0]                  scan_limit_i,
  input  logic [fca_pkg::EntryW-1:0]   rdata_i,
  output fca_pkg::mem_req_t            mem_req_o,
  output fca_pkg::result_t             result_o
);

  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SRead  = 3'd2;
  localparam logic [2:0] SScan  = 3'd3;
  localparam logic [2:0] SLink  = 3'd4;
  localparam logic [2:0] SMark  = 3'd5;

  localparam logic [12:0] EntriesC = 13'(fca_pkg::TableEntries);

  logic [2:0]                     state_q, state_d;
  logic [12:0]                    pos_q, pos_d;
  logic [fca_pkg::AddrW-1:0]      chk_q, chk_d;
  logic                           chk_vld_q, chk_vld_d;
  logic [fca_pkg::AddrW-1:0]      prev_q, prev_d;
  logic [fca_pkg::EntryW-1:0]     first_q, first_d;
  logic [fca_pkg::CountW-1:0]     claimed_q, claimed_d;
  logic [fca_pkg::NeedW-1:0]      need_q, need_d;
  logic                           rd_ok_q, rd_ok_d;
  fca_pkg::result_t               res_q, res_d;

  logic                           accept;
  logic                           idx_ok;
  logic [12:0]                    limit;
  logic [fca_pkg::NeedW-1:0]      need_calc;
  logic [fca_pkg::CountW-1:0]     claimed_inc;
  logic                           found;

  assign busy     = (state_q != SIdle);
  assign accept   = start && !busy;
  assign idx_ok   = ({1'b0, entry_index_i} < EntriesC);
  assign limit    = (scan_limit_i > EntriesC) ? EntriesC : scan_limit_i;
  assign need_calc = fca_pkg::NeedW'(({1'b0, byte_count_i} +
                     fca_pkg::NeedW'(fca_pkg::ClusterBytes - 1)) >> fca_pkg::ClusterShift);
  assign claimed_inc = claimed_q + 1'b1;
  assign found       = chk_vld_q && (rdata_i == '0);

  // Sequencer and table port selection
  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    chk_d     = chk_q;
    chk_vld_d = chk_vld_q;
    prev_d    = prev_q;
    first_d   = first_q;
    claimed_d = claimed_q;
    need_d    = need_q;
    rd_ok_d   = rd_ok_q;
    res_d     = '0;
    mem_req_o = '0;
    mem_req_o.raddr = pos_q[fca_pkg::AddrW-1:0];

    unique case (state_q)
      SClear: begin
        // Zero one entry a cycle
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = pos_q[fca_pkg::AddrW-1:0];
        pos_d           = pos_q + 1'b1;
        if (pos_q == EntriesC - 1'b1) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (accept) begin
          unique case (mode_i)
            fca_pkg::ModeWrite: begin
              mem_req_o.we    = idx_ok;
              mem_req_o.waddr = entry_index_i[fca_pkg::AddrW-1:0];
              mem_req_o.wdata = entry_value_i;
              res_d.valid     = 1'b1;
            end
            fca_pkg::ModeRead: begin
              mem_req_o.raddr = entry_index_i[fca_pkg::AddrW-1:0];
              rd_ok_d         = idx_ok;
              state_d         = SRead;
            end
            fca_pkg::ModeAlloc: begin
              if (byte_count_i == '0) begin
                res_d.valid  = 1'b1;
                res_d.status = fca_pkg::StZero;
              end else begin
                need_d    = need_calc;
                pos_d     = '0;
                chk_vld_d = 1'b0;
                claimed_d = '0;
                first_d   = '0;
                state_d   = SScan;
              end
            end
            default: begin
              res_d.valid = 1'b1;
            end
          endcase
        end
      end
      SRead: begin
        res_d.valid    = 1'b1;
        res_d.rd_value = rd_ok_q ? rdata_i : '0;
        state_d        = SIdle;
      end
      SScan: begin
        // Check the word read last cycle, issue the next address
        priority if (found) begin
          chk_vld_d = 1'b0;
          state_d   = (claimed_q != '0) ? SLink : SMark;
        end else if (pos_q < limit) begin
          mem_req_o.raddr = pos_q[fca_pkg::AddrW-1:0];
          chk_d     = pos_q[fca_pkg::AddrW-1:0];
          chk_vld_d = 1'b1;
          pos_d     = pos_q + 1'b1;
        end else begin
          res_d.valid  = 1'b1;
          res_d.status = fca_pkg::StNoSpace;
          res_d.first  = first_q;
          res_d.count  = claimed_q;
          state_d      = SIdle;
        end
      end
      SLink: begin
        // Link the previous cluster to the new one
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = prev_q;
        mem_req_o.wdata = fca_pkg::EntryW'(chk_q);
        state_d         = SMark;
      end
      SMark: begin
        // Mark the new cluster as end of chain
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = chk_q;
        mem_req_o.wdata = fca_pkg::EndOfChain;
        prev_d          = chk_q;
        claimed_d       = claimed_inc;
        if (claimed_q == '0) begin
          first_d = fca_pkg::EntryW'(chk_q);
        end
        if (fca_pkg::NeedW'(claimed_inc) == need_q) begin
          res_d.valid  = 1'b1;
          res_d.status = fca_pkg::StOk;
          res_d.first  = (claimed_q == '0) ? fca_pkg::EntryW'(chk_q) : first_q;
          res_d.count  = claimed_inc;
          state_d      = SIdle;
        end else begin
          pos_d   = {1'b0, chk_q} + 1'b1;
          state_d = SScan;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SClear;
      pos_q     <= '0;
      chk_vld_q <= 1'b0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      chk_vld_q <= chk_vld_d;
      res_q     <= res_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    chk_q     <= chk_d;
    prev_q    <= prev_d;
    first_q   <= first_d;
    claimed_q <= claimed_d;
    need_q    <= need_d;
    rd_ok_q   <= rd_ok_d;
  end

  assign result_o = res_q;

endmodule

FILE: hw/rtl/fat12_cluster_chain_allocator_unit.sv
// Top level of the cluster chain allocator: scan limit register, table RAM
// and sequencer. Depends on fca_pkg, fca_ram and fca_ctrl.

// After reset the block clears its 4096-entry table, one entry a cycle, and
// holds busy high until the clear is done. A request is taken when start is
// high and busy low. A write finishes in the idle state and a read passes
// through the read state. An allocation walks the table from entry zero up to
// the scan limit at one entry a cycle through the single read port, and pauses
// on each cluster it claims to link the one before (if any) to it, mark it as
// end of chain and restart the walk after it. Each request gives one result on
// done_o for exactly one cycle; the receiver must take it then, it cannot
// stall the block. The scan limit may be written only while the block is idle.
module fat12_cluster_chain_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [11:0] entry_index_i,
  input  logic [11:0] entry_value_i,
  input  logic [21:0] byte_count_i,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [11:0] first_cluster_o,
  output logic [12:0] clusters_claimed_o,
  output logic [11:0] read_value_o
);

  logic [12:0]                scan_limit_q;
  fca_pkg::mem_req_t          mem_req;
  fca_pkg::result_t           result;
  logic [fca_pkg::EntryW-1:0] rdata;

  // Hold the scan limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_limit_q <= fca_pkg::ScanLimitReset;
    end else if (cfg_we_i) begin
      scan_limit_q <= cfg_wdata_i;
    end
  end

  fca_ram #(
    .Width (fca_pkg::EntryW),
    .Depth (fca_pkg::TableEntries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  fca_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .byte_count_i  (byte_count_i),
    .scan_limit_i  (scan_limit_q),
    .rdata_i       (rdata),
    .mem_req_o     (mem_req),
    .result_o      (result)
  );

  // Drive the result ports
  assign done_o             = result.valid;
  assign status_o           = result.status;
  assign first_cluster_o    = result.first;
  assign clusters_claimed_o = result.count;
  assign read_value_o       = result.rd_value;

endmodule

FILE: verif/fca_table_tracker.sv
// Watches the allocator's request, configuration and result ports, predicts each result
// from a private copy of the allocation table, and counts mismatches.
// Depends on fca_pkg.
`timescale 1ns / 100ps

module fca_table_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [11:0] entry_index_i,
  input  logic [11:0] entry_value_i,
  input  logic [21:0] byte_count_i,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        done_o,
  input  logic [1:0]  status_o,
  input  logic [11:0] first_cluster_o,
  input  logic [12:0] clusters_claimed_o,
  input  logic [11:0] read_value_o,
  output int unsigned fail_count,
  output int unsigned outstanding
);

  typedef struct packed {
    logic [1:0]                 status;
    logic [fca_pkg::EntryW-1:0] first;
    logic [fca_pkg::CountW-1:0] claimed;
    logic [fca_pkg::EntryW-1:0] rd_value;
  } reply_t;

  // Shadow of the allocation table and the scan limit register
  logic [fca_pkg::EntryW-1:0] shadow_fat [fca_pkg::TableEntries];
  logic [fca_pkg::CountW-1:0] scan_lim;
  reply_t                     replies_q[$];
  int unsigned                mismatches = 0;

  // Apply one request to the shadow table and work out its reply
  function automatic reply_t claim_or_access(input logic [1:0] md, input logic [11:0] idx,
                                             input logic [11:0] val,
                                             input logic [21:0] nbytes);
    reply_t                     r;
    int unsigned                need, got, lim, pos;
    logic [fca_pkg::EntryW-1:0] prev;
    bit                         linked, full;
    r      = '0;
    got    = 0;
    pos    = 0;
    prev   = '0;
    linked = 1'b0;
    full   = 1'b0;
    case (md)
      fca_pkg::ModeWrite: shadow_fat[idx] = val;
      fca_pkg::ModeRead:  r.rd_value = shadow_fat[idx];
      fca_pkg::ModeAlloc: begin
        if (nbytes == '0) begin
          r.status = fca_pkg::StZero;
        end else begin
          lim  = (scan_lim > fca_pkg::TableEntries) ? fca_pkg::TableEntries : scan_lim;
          need = (nbytes + fca_pkg::ClusterBytes - 1) / fca_pkg::ClusterBytes;
          r.status = fca_pkg::StOk;
          // Claim the lowest free entries in turn, linking each to the next
          while (got < need && !full) begin
            while (pos < lim && shadow_fat[pos] != '0) pos++;
            if (pos >= lim) begin
              full = 1'b1;
            end else begin
              if (linked) shadow_fat[prev] = pos[fca_pkg::EntryW-1:0];
              else r.first = pos[fca_pkg::EntryW-1:0];
              shadow_fat[pos] = fca_pkg::EndOfChain;
              prev   = pos[fca_pkg::EntryW-1:0];
              linked = 1'b1;
              got++;
            end
          end
          if (full) r.status = fca_pkg::StNoSpace;
          r.claimed = got[fca_pkg::CountW-1:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Track configuration, accepted requests and results at each edge
  always @(posedge clk_i or negedge rst_ni) begin : track
    reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < fca_pkg::TableEntries; i++) shadow_fat[i] = '0;
      scan_lim = fca_pkg::ScanLimitReset;
      replies_q.delete();
    end else begin
      if (cfg_we_i) scan_lim = cfg_wdata_i;
      if (start && !busy)
        replies_q.push_back(claim_or_access(mode_i, entry_index_i, entry_value_i,
                                            byte_count_i));
      if (done_o) begin
        if (replies_q.size() == 0) begin
          mismatches++;
          $error("result strobe with no request outstanding");
        end else begin
          want = replies_q.pop_front();
          if (status_o !== want.status) begin
            mismatches++;
            $error("status: expected %0d, got %0d", want.status, status_o);
          end
          if (first_cluster_o !== want.first) begin
            mismatches++;
            $error("first_cluster: expected %0d, got %0d", want.first, first_cluster_o);
          end
          if (clusters_claimed_o !== want.claimed) begin
            mismatches++;
            $error("clusters_claimed: expected %0d, got %0d", want.claimed,
                   clusters_claimed_o);
          end
          if (read_value_o !== want.rd_value) begin
            mismatches++;
            $error("read_value: expected %0d, got %0d", want.rd_value, read_value_o);
          end
        end
      end
    end
    fail_count  <= mismatches;
    outstanding <= replies_q.size();
  end

endmodule

FILE: verif/fat12_cluster_chain_allocator_unit_tb.sv
// Testbench top of the cluster chain allocator: clock, reset, request and scan
// limit stimulus, and the verdict. Depends on fca_pkg, the block and fca_table_tracker.
`timescale 1ns / 100ps

module fat12_cluster_chain_allocator_unit_tb;

  localparam logic [1:0] ModeUnused = 2'd3;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        start         = 1'b0;
  logic [1:0]  mode_i        = fca_pkg::ModeRead;
  logic [11:0] entry_index_i = '0;
  logic [11:0] entry_value_i = '0;
  logic [21:0] byte_count_i  = '0;
  logic        cfg_we_i      = 1'b0;
  logic [12:0] cfg_wdata_i   = '0;
  logic        busy;
  logic        done_o;
  logic [1:0]  status_o;
  logic [11:0] first_cluster_o;
  logic [12:0] clusters_claimed_o;
  logic [11:0] read_value_o;
  int unsigned fail_count;
  int unsigned outstanding;

  int unsigned burst_left = 0;
  int unsigned n_alloc = 0, n_read = 0, n_write = 0, n_unused = 0, n_limit = 0;

  always #6 clk_i = ~clk_i;

  fat12_cluster_chain_allocator_unit DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .mode_i             (mode_i),
    .entry_index_i      (entry_index_i),
    .entry_value_i      (entry_value_i),
    .byte_count_i       (byte_count_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .first_cluster_o    (first_cluster_o),
    .clusters_claimed_o (clusters_claimed_o),
    .read_value_o       (read_value_o)
  );

  fca_table_tracker u_tracker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .mode_i             (mode_i),
    .entry_index_i      (entry_index_i),
    .entry_value_i      (entry_value_i),
    .byte_count_i       (byte_count_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .first_cluster_o    (first_cluster_o),
    .clusters_claimed_o (clusters_claimed_o),
    .read_value_o       (read_value_o),
    .fail_count         (fail_count),
    .outstanding        (outstanding)
  );

  // Random entry-sized and byte-count-sized values
  function automatic logic [11:0] rnd_entry();
    return 12'($urandom);
  endfunction

  function automatic logic [21:0] rnd_bytes();
    return 22'($urandom);
  endfunction

  // Hold the request line low between most bursts of random length
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // Present one request and hold it until the block takes it
  task automatic issue(input logic [1:0] md, input logic [11:0] idx, input logic [11:0] val,
                       input logic [21:0] nbytes);
    pace();
    start         <= 1'b1;
    mode_i        <= md;
    entry_index_i <= idx;
    entry_value_i <= val;
    byte_count_i  <= nbytes;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    case (md)
      fca_pkg::ModeWrite: n_write++;
      fca_pkg::ModeRead:  n_read++;
      fca_pkg::ModeAlloc: n_alloc++;
      default:            n_unused++;
    endcase
  endtask

  // Drain every outstanding request, then write the scan limit while idle
  task automatic set_scan_limit(input logic [12:0] lim);
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0 || busy) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    n_limit++;
  endtask

  // Free the searched entries if at most 64, then mix writes, reads, allocs, unused modes
  task automatic run_random(input int unsigned lim, input int unsigned count);
    int unsigned span, pick;
    logic [11:0] idx, val;
    logic [21:0] nbytes;
    span = (lim == 0) ? 1 :
           ((lim > fca_pkg::TableEntries) ? fca_pkg::TableEntries : lim);
    if (span <= 64)
      for (int i = 0; i < span; i++) issue(fca_pkg::ModeWrite, 12'(i), '0, rnd_bytes());
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      idx  = ($urandom_range(0, 9) == 0) ? rnd_entry() : 12'($urandom_range(0, span - 1));
      if (pick < 30) begin
        val = ($urandom_range(0, 9) < 7) ? '0 : rnd_entry();
        issue(fca_pkg::ModeWrite, idx, val, rnd_bytes());
      end else if (pick < 50) begin
        issue(fca_pkg::ModeRead, idx, rnd_entry(), rnd_bytes());
      end else if (pick < 95) begin
        case ($urandom_range(0, 19))
          0, 1:    nbytes = '0;
          2, 3, 4: nbytes = 22'($urandom_range(0, 2097152));
          default: nbytes = 22'($urandom_range(1, span * 256 + 1));
        endcase
        issue(fca_pkg::ModeAlloc, rnd_entry(), rnd_entry(), nbytes);
      end else begin
        issue(ModeUnused, rnd_entry(), rnd_entry(), rnd_bytes());
      end
    end
  endtask

  // Stimulus: directed corner cases, then random phases over several scan limits
  initial begin : stimulus
    int unsigned lim;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset scan limit: entry extremes, empty and partial chains, full scan range
    issue(fca_pkg::ModeRead,  12'd0,       rnd_entry(), rnd_bytes());
    issue(fca_pkg::ModeWrite, 12'hFFF,     12'hFFF,     rnd_bytes());
    issue(fca_pkg::ModeRead,  12'hFFF,     rnd_entry(), rnd_bytes());
    issue(fca_pkg::ModeWrite, 12'hFFF,     12'h000,     rnd_bytes());
    issue(fca_pkg::ModeAlloc, rnd_entry(), rnd_entry(), 22'd0);
    issue(fca_pkg::ModeAlloc, rnd_entry(), rnd_entry(), 22'd1);
    issue(fca_pkg::ModeAlloc, rnd_entry(), rnd_entry(), 22'd512);
    issue(fca_pkg::ModeAlloc, rnd_entry(), rnd_entry(), 22'd513);
    issue(fca_pkg::ModeRead,  12'd2,       rnd_entry(), rnd_bytes());
    issue(ModeUnused,         12'hFFF,     12'hFFF,     22'h3FFFFF);
    issue(fca_pkg::ModeAlloc, rnd_entry(), rnd_entry(), 22'd2097152);
    issue(fca_pkg::ModeAlloc, rnd_entry(), rnd_entry(), 22'd1);
    issue(fca_pkg::ModeWrite, 12'd100,     12'h000,     rnd_bytes());
    issue(fca_pkg::ModeAlloc, rnd_entry(), rnd_entry(), 22'd1000);
    issue(fca_pkg::ModeRead,  12'd100,     rnd_entry(), rnd_bytes());

    // Zero scan limit finds nothing
    set_scan_limit(13'd0);
    issue(fca_pkg::ModeAlloc, rnd_entry(), rnd_entry(), 22'd1);
    issue(fca_pkg::ModeAlloc, rnd_entry(), rnd_entry(), 22'd0);

    // Oversized scan limit reaches the top of the table
    set_scan_limit(13'h1FFF);
    issue(fca_pkg::ModeAlloc, rnd_entry(), rnd_entry(), 22'd2097152);
    issue(fca_pkg::ModeRead,  12'hFFF,     rnd_entry(), rnd_bytes());

    set_scan_limit(13'd16);
    run_random(16, 25);
    set_scan_limit(13'd1);
    run_random(1, 8);
    lim = $urandom_range(24, 40);
    set_scan_limit(13'(lim));
    run_random(lim, 20);
    set_scan_limit(13'd2);
    run_random(2, 8);
    set_scan_limit(13'd4096);
    run_random(4096, 12);

    // Drain, then allow for a stray late result
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    $display("Covered %0d allocations, %0d reads, %0d writes and %0d unused-mode requests",
             n_alloc, n_read, n_write, n_unused);
    $display("Scan limit written %0d times, from zero to beyond the table size", n_limit);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Bound the run in case the block hangs
  initial begin
    #150_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
